/* hw/rtl/mtep_pkg.sv */
`default_nettype none
package mtep_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] DATA_MASK_BIT = 8'h80;
  localparam logic [7:0] META_END_TYPE = 8'h2F;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] LO_SYSEX      = 4'h0;
  localparam logic [3:0] LO_ESCAPE     = 4'h7;
  localparam logic [3:0] LO_META       = 4'hF;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  bytes_present;
    logic [31:0] delta_ticks;
    logic [31:0] tick_total;
    logic        last_of_run;
  } result_t;

  function automatic result_t make_result(kind_t k, logic [7:0] st, logic [7:0] d1,
                                          logic [7:0] d2, logic [1:0] nb,
                                          logic [31:0] dl, logic [31:0] tot);
    result_t r;
    r.kind          = k;
    r.status_byte   = st;
    r.first_data    = d1;
    r.second_data   = d2;
    r.bytes_present = nb;
    r.delta_ticks   = dl;
    r.tick_total    = tot;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mtep_ifs.sv */
`default_nettype none
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       chunk_end;

  modport source (output valid, output byte_in, output chunk_end, input ready);
  modport sink (input valid, input byte_in, input chunk_end, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [1:0]  bytes_present;
  logic [31:0] delta_ticks;
  logic [31:0] tick_total;
  logic        last_of_run;

  modport source (output valid, output kind, output status_byte, output first_data,
                  output second_data, output bytes_present, output delta_ticks,
                  output tick_total, output last_of_run, input ready);
  modport sink (input valid, input kind, input status_byte, input first_data,
                input second_data, input bytes_present, input delta_ticks,
                input tick_total, input last_of_run, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mtep_parser.sv */
`default_nettype none
module mtep_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      byte_in,
  input  wire logic            chunk_end,
  output mtep_pkg::result_t    res0,
  output mtep_pkg::result_t    res1,
  output logic [1:0]           res_cnt
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SYSLEN,
    PH_METATYP, PH_METALEN, PH_SKIP, PH_DONE, PH_ERROR
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] delta_acc, delta_acc_next;
  logic [31:0] tick_sum, tick_sum_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  event_status, event_status_next;
  logic [7:0]  held_data, held_data_next;
  logic        meta_is_end, meta_is_end_next;
  logic [31:0] skip_count, skip_count_next;

  mtep_pkg::result_t proc_res, end_res0, end_res1;
  logic              proc_v;
  logic [1:0]        end_cnt;
  logic              rerun;
  logic              one_data;
  logic [31:0]       shifted_skip;
  logic [31:0]       end_total;

  always_comb begin
    phase_next          = phase;
    delta_acc_next      = delta_acc;
    tick_sum_next       = tick_sum;
    running_status_next = running_status;
    event_status_next   = event_status;
    held_data_next      = held_data;
    meta_is_end_next    = meta_is_end;
    skip_count_next     = skip_count;
    proc_v              = 1'b0;
    proc_res            = '0;
    rerun               = 1'b0;
    one_data            = 1'b0;
    shifted_skip        = {skip_count[24:0], byte_in[6:0]};

    unique case (phase)
      PH_DELTA: begin
        delta_acc_next = {delta_acc[24:0], byte_in[6:0]};
        if (!byte_in[7]) phase_next = PH_STATUS;
      end
      PH_STATUS: begin
        if (byte_in[7]) begin
          event_status_next   = byte_in;
          running_status_next = byte_in;
        end else if (running_status != 8'h00) begin
          event_status_next = running_status;
          rerun             = 1'b1;
        end
        if (!byte_in[7] && running_status == 8'h00) begin
          proc_v     = 1'b1;
          proc_res   = mtep_pkg::make_result(mtep_pkg::KIND_ERROR, 8'h00, 8'h00, 8'h00,
                                             2'd0, 32'd0, tick_sum);
          phase_next = PH_ERROR;
        end else if (event_status_next[7:4] != mtep_pkg::HI_SYSTEM) begin
          phase_next = PH_DATA1;
          one_data = (event_status_next[7:4] == mtep_pkg::HI_PROGRAM) ||
                     (event_status_next[7:4] == mtep_pkg::HI_PRESSURE);
          if (rerun) begin
            held_data_next = byte_in;
            if (one_data) begin
              tick_sum_next  = tick_sum + delta_acc;
              proc_v         = 1'b1;
              proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT,
                                 event_status_next, byte_in, 8'h00, 2'd2, delta_acc,
                                 tick_sum_next);
              delta_acc_next = '0;
              phase_next     = PH_DELTA;
            end else begin
              phase_next = PH_DATA2;
            end
          end
        end else if (event_status_next[3:0] == mtep_pkg::LO_SYSEX ||
                     event_status_next[3:0] == mtep_pkg::LO_ESCAPE) begin
          skip_count_next = '0;
          phase_next      = PH_SYSLEN;
          if (rerun) begin
            skip_count_next = {25'd0, byte_in[6:0]};
            if (byte_in[6:0] == 7'd0) begin
              tick_sum_next  = tick_sum + delta_acc;
              proc_v         = 1'b1;
              proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT,
                                 event_status_next, 8'h00, 8'h00, 2'd0, delta_acc,
                                 tick_sum_next);
              delta_acc_next = '0;
              phase_next     = PH_DELTA;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end else if (event_status_next[3:0] == mtep_pkg::LO_META) begin
          phase_next = PH_METATYP;
          if (rerun) begin
            meta_is_end_next = (byte_in == mtep_pkg::META_END_TYPE);
            skip_count_next  = '0;
            phase_next       = PH_METALEN;
          end
        end else begin
          tick_sum_next = tick_sum + delta_acc;
          proc_v        = 1'b1;
          proc_res      = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status_next,
                            8'h00, 8'h00, 2'd0, delta_acc, tick_sum_next);
          if (rerun) begin
            delta_acc_next = {25'd0, byte_in[6:0]};
            phase_next     = PH_STATUS;
          end else begin
            delta_acc_next = '0;
            phase_next     = PH_DELTA;
          end
        end
      end
      PH_DATA1: begin
        held_data_next = byte_in;
        one_data = (event_status[7:4] == mtep_pkg::HI_PROGRAM) ||
                   (event_status[7:4] == mtep_pkg::HI_PRESSURE);
        if (one_data) begin
          tick_sum_next  = tick_sum + delta_acc;
          proc_v         = 1'b1;
          proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status,
                             byte_in, 8'h00, 2'd2, delta_acc, tick_sum_next);
          delta_acc_next = '0;
          phase_next     = PH_DELTA;
        end else begin
          phase_next = PH_DATA2;
        end
      end
      PH_DATA2: begin
        tick_sum_next  = tick_sum + delta_acc;
        proc_v         = 1'b1;
        proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status,
                           held_data, byte_in, 2'd3, delta_acc, tick_sum_next);
        delta_acc_next = '0;
        phase_next     = PH_DELTA;
      end
      PH_SYSLEN: begin
        skip_count_next = shifted_skip;
        if (!byte_in[7]) begin
          if (shifted_skip == 32'd0) begin
            tick_sum_next  = tick_sum + delta_acc;
            proc_v         = 1'b1;
            proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status,
                               8'h00, 8'h00, 2'd0, delta_acc, tick_sum_next);
            delta_acc_next = '0;
            phase_next     = PH_DELTA;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_METATYP: begin
        meta_is_end_next = (byte_in == mtep_pkg::META_END_TYPE);
        skip_count_next  = '0;
        phase_next       = PH_METALEN;
      end
      PH_METALEN: begin
        skip_count_next = shifted_skip;
        if (!byte_in[7]) begin
          if (meta_is_end && (shifted_skip == 32'd0 || !chunk_end)) begin
            proc_v     = 1'b1;
            proc_res   = mtep_pkg::make_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00,
                                               2'd0, 32'd0, tick_sum);
            phase_next = PH_DONE;
          end else if (shifted_skip == 32'd0) begin
            tick_sum_next  = tick_sum + delta_acc;
            proc_v         = 1'b1;
            proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status,
                               8'h00, 8'h00, 2'd0, delta_acc, tick_sum_next);
            delta_acc_next = '0;
            phase_next     = PH_DELTA;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_count - 32'd1;
        if (skip_count == 32'd1) begin
          tick_sum_next  = tick_sum + delta_acc;
          proc_v         = 1'b1;
          proc_res       = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status,
                             8'h00, 8'h00, 2'd0, delta_acc, tick_sum_next);
          delta_acc_next = '0;
          phase_next     = PH_DELTA;
        end
      end
      default: begin
      end
    endcase
  end

  // At the chunk's last byte, a begun event is flushed and the track total follows.
  always_comb begin
    end_cnt   = 2'd0;
    end_res0  = '0;
    end_res1  = '0;
    end_total = tick_sum_next + delta_acc_next;
    if (chunk_end) begin
      unique case (phase_next)
        PH_DELTA, PH_STATUS: begin
          end_cnt  = 2'd1;
          end_res0 = mtep_pkg::make_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00, 2'd0,
                                           32'd0, tick_sum_next);
        end
        PH_DATA1, PH_DATA2, PH_SYSLEN, PH_SKIP, PH_METATYP: begin
          end_cnt  = 2'd2;
          end_res0 = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status_next,
                       (phase_next == PH_DATA2) ? held_data_next : 8'h00, 8'h00,
                       (phase_next == PH_DATA1) ? 2'd1 :
                       (phase_next == PH_DATA2) ? 2'd2 : 2'd0,
                       delta_acc_next, end_total);
          end_res1 = mtep_pkg::make_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00, 2'd0,
                                           32'd0, end_total);
        end
        PH_METALEN: begin
          if (meta_is_end_next) begin
            end_cnt  = 2'd1;
            end_res0 = mtep_pkg::make_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00,
                                             2'd0, 32'd0, tick_sum_next);
          end else begin
            end_cnt  = 2'd2;
            end_res0 = mtep_pkg::make_result(mtep_pkg::KIND_EVENT, event_status_next,
                         8'h00, 8'h00, 2'd0, delta_acc_next, end_total);
            end_res1 = mtep_pkg::make_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00,
                                             2'd0, 32'd0, end_total);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_cnt = {1'b0, proc_v} + end_cnt;
    res0    = proc_v ? proc_res : end_res0;
    res1    = proc_v ? end_res0 : end_res1;
    res0.last_of_run = (res_cnt == 2'd1);
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && chunk_end)) begin
      phase          <= PH_DELTA;
      delta_acc      <= '0;
      tick_sum       <= '0;
      running_status <= '0;
      event_status   <= '0;
      held_data      <= '0;
      meta_is_end    <= 1'b0;
      skip_count     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      delta_acc      <= delta_acc_next;
      tick_sum       <= tick_sum_next;
      running_status <= running_status_next;
      event_status   <= event_status_next;
      held_data      <= held_data_next;
      meta_is_end    <= meta_is_end_next;
      skip_count     <= skip_count_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mtep_res_fifo.sv */
`default_nettype none
module mtep_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_cnt,
  input  wire mtep_pkg::result_t push0,
  input  wire mtep_pkg::result_t push1,
  output logic                   room,
  mtep_out_if.source             events
);

  mtep_pkg::result_t mem [4];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  logic [2:0]        count;
  logic              pop;
  mtep_pkg::result_t head;

  assign head    = mem[rd_ptr];
  assign pop     = events.valid && events.ready;
  assign room    = (count <= 3'd2);

  assign events.valid         = (count != 3'd0);
  assign events.kind          = head.kind;
  assign events.status_byte   = head.status_byte;
  assign events.first_data    = head.first_data;
  assign events.second_data   = head.second_data;
  assign events.bytes_present = head.bytes_present;
  assign events.delta_ticks   = head.delta_ticks;
  assign events.tick_total    = head.tick_total;
  assign events.last_of_run   = head.last_of_run;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr] <= push0;
    if (push_cnt == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/midi_track_event_parser_unit.sv */
`default_nettype none
// Parses the body of a standard MIDI file track chunk, one byte per item.
// The track channel carries byte_in and chunk_end, which marks the chunk's
// last byte. The events channel carries one result per item: channel and
// system events with their delta time, the track end with the total tick
// count, or a running status error. One byte may cause zero, one or two
// results; last_of_run marks the final one of a byte.
// A byte is taken into an input register, parsed once the result queue has
// room for two results, and its results are written to that four-entry queue.
// A byte is accepted every cycle while the queue holds no more than two
// results, so the rate is one byte per cycle when each byte causes at most
// one result and the receiver keeps up. A stalled receiver fills the queue,
// then the input register, and the block stops taking bytes.
// After the chunk's last byte the parse state returns to its reset values.
// Reset empties the input register and the queue and clears the parse
// state, with no running status and the delta time at zero.
module midi_track_event_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  mtep_in_if.sink    track,
  mtep_out_if.source events
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_last;
  logic              room;
  logic              step;
  logic [1:0]        res_cnt;
  logic [1:0]        push_cnt;
  mtep_pkg::result_t res0;
  mtep_pkg::result_t res1;

  assign step        = held_valid && room;
  assign track.ready = !held_valid || room;
  assign push_cnt    = step ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (track.ready) begin
      held_valid <= track.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (track.valid && track.ready) begin
      held_byte <= track.byte_in;
      held_last <= track.chunk_end;
    end
  end

  mtep_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (held_byte),
    .chunk_end (held_last),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  mtep_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .events   (events)
  );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [3:0] {
    WAIT_DELTA,
    WAIT_STATUS,
    WAIT_FIRST,
    WAIT_SECOND,
    WAIT_SYS_LEN,
    WAIT_META_TYPE,
    WAIT_META_LEN,
    SKIPPING_BODY,
    TRACK_DONE,
    TRACK_ERROR
  } parse_phase_t;

  class track_scoreboard;
    parse_phase_t          phase;
    logic [31:0]           delta_acc;
    logic [31:0]           tick_sum;
    logic [31:0]           skip_count;
    logic [7:0]            running_status;
    logic [7:0]            event_status;
    logic [7:0]            held_data;
    logic                  meta_is_end;
    mtep_pkg::result_t     step_results[$];
    mtep_pkg::result_t     expected_events[$];
    int                    errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase          = WAIT_DELTA;
      delta_acc      = 32'd0;
      tick_sum       = 32'd0;
      skip_count     = 32'd0;
      running_status = 8'h00;
      event_status   = 8'h00;
      held_data      = 8'h00;
      meta_is_end    = 1'b0;
    endfunction

    function void add_result(mtep_pkg::kind_t k, logic [7:0] st, logic [7:0] d1,
                             logic [7:0] d2, logic [1:0] nb, logic [31:0] dl);
      mtep_pkg::result_t r;
      if (step_results.size() >= 2) return;
      r.kind          = k;
      r.status_byte   = st;
      r.first_data    = d1;
      r.second_data   = d2;
      r.bytes_present = nb;
      r.delta_ticks   = dl;
      r.tick_total    = tick_sum;
      r.last_of_run   = 1'b0;
      step_results = {step_results, r};
    endfunction

    function void close_event(logic [7:0] d1, logic [7:0] d2, logic [1:0] nb);
      logic [31:0] dl;
      dl = delta_acc;
      tick_sum = tick_sum + dl;
      add_result(mtep_pkg::KIND_EVENT, event_status, d1, d2, nb, dl);
      delta_acc = 32'd0;
      phase = WAIT_DELTA;
    endfunction

    function void close_track();
      add_result(mtep_pkg::KIND_END, 8'h00, 8'h00, 8'h00, 2'd0, 32'd0);
      phase = TRACK_DONE;
    endfunction

    function void parse_byte(logic [7:0] b, bit last);
      bit         again;
      bit         is_data;
      logic [3:0] hi;
      logic [3:0] lo;
      is_data = (b & mtep_pkg::DATA_MASK_BIT) == 8'h00;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (phase)
          WAIT_DELTA: begin
            delta_acc = {delta_acc[24:0], b[6:0]};
            if (is_data) phase = WAIT_STATUS;
          end
          WAIT_STATUS: begin
            if (is_data && running_status == 8'h00) begin
              add_result(mtep_pkg::KIND_ERROR, 8'h00, 8'h00, 8'h00, 2'd0, 32'd0);
              phase = TRACK_ERROR;
            end else begin
              if (!is_data) begin
                event_status   = b;
                running_status = b;
              end else begin
                event_status = running_status;
                again = 1'b1;
              end
              hi = event_status[7:4];
              lo = event_status[3:0];
              if (hi != mtep_pkg::HI_SYSTEM) begin
                phase = WAIT_FIRST;
              end else if (lo == mtep_pkg::LO_SYSEX || lo == mtep_pkg::LO_ESCAPE) begin
                skip_count = 32'd0;
                phase = WAIT_SYS_LEN;
              end else if (lo == mtep_pkg::LO_META) begin
                phase = WAIT_META_TYPE;
              end else begin
                close_event(8'h00, 8'h00, 2'd0);
              end
            end
          end
          WAIT_FIRST: begin
            held_data = b;
            hi = event_status[7:4];
            if (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_PRESSURE)
              close_event(b, 8'h00, 2'd2);
            else phase = WAIT_SECOND;
          end
          WAIT_SECOND: begin
            close_event(held_data, b, 2'd3);
          end
          WAIT_SYS_LEN: begin
            skip_count = {skip_count[24:0], b[6:0]};
            if (is_data) begin
              if (skip_count == 32'd0) close_event(8'h00, 8'h00, 2'd0);
              else phase = SKIPPING_BODY;
            end
          end
          WAIT_META_TYPE: begin
            meta_is_end = (b == mtep_pkg::META_END_TYPE);
            skip_count = 32'd0;
            phase = WAIT_META_LEN;
          end
          WAIT_META_LEN: begin
            skip_count = {skip_count[24:0], b[6:0]};
            if (is_data) begin
              if (meta_is_end && (skip_count == 32'd0 || !last)) close_track();
              else if (skip_count == 32'd0) close_event(8'h00, 8'h00, 2'd0);
              else phase = SKIPPING_BODY;
            end
          end
          SKIPPING_BODY: begin
            skip_count = skip_count - 32'd1;
            if (skip_count == 32'd0) close_event(8'h00, 8'h00, 2'd0);
          end
          default: begin
          end
        endcase
      end
    endfunction

    function void accept_byte(logic [7:0] b, bit last);
      step_results.delete();
      parse_byte(b, last);
      if (last) begin
        case (phase)
          WAIT_DELTA, WAIT_STATUS: begin
            close_track();
          end
          WAIT_FIRST: begin
            close_event(8'h00, 8'h00, 2'd1);
            close_track();
          end
          WAIT_SECOND: begin
            close_event(held_data, 8'h00, 2'd2);
            close_track();
          end
          WAIT_SYS_LEN, SKIPPING_BODY, WAIT_META_TYPE: begin
            close_event(8'h00, 8'h00, 2'd0);
            close_track();
          end
          WAIT_META_LEN: begin
            if (!meta_is_end) close_event(8'h00, 8'h00, 2'd0);
            close_track();
          end
          default: begin
          end
        endcase
      end
      if (step_results.size() > 0)
        step_results[step_results.size() - 1].last_of_run = 1'b1;
      expected_events = {expected_events, step_results};
      if (last) clear_parse();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(mtep_pkg::result_t got);
      mtep_pkg::result_t want;
      if (expected_events.size() == 0) begin
        $error("result with none expected, kind 0x%0h", got.kind);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
      compare_field("first_data", 32'(want.first_data), 32'(got.first_data));
      compare_field("second_data", 32'(want.second_data), 32'(got.second_data));
      compare_field("bytes_present", 32'(want.bytes_present), 32'(got.bytes_present));
      compare_field("delta_ticks", want.delta_ticks, got.delta_ticks);
      compare_field("tick_total", want.tick_total, got.tick_total);
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction

    function int pending_count();
      return expected_events.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mtep_in_if  track_if ();
  mtep_out_if events_if ();

  midi_track_event_parser_unit dut (
    .clk    (clk),
    .rst    (rst),
    .track  (track_if),
    .events (events_if)
  );

  track_scoreboard board = new();
  logic [7:0]      chunk_bytes[$];
  bit              fast_in = 1'b0;
  bit              fast_out = 1'b0;
  bit              hold_request = 1'b0;
  int              cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** midi_track_event_parser_unit: FAILED **");
      $finish;
    end
  end

  task automatic append_byte(input logic [7:0] b);
    chunk_bytes = {chunk_bytes, b};
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      track_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    track_if.valid     <= 1'b1;
    track_if.byte_in   <= b;
    track_if.chunk_end <= last;
    @(posedge clk);
    while (!track_if.ready) @(posedge clk);
    board.accept_byte(b, last);
  endtask

  task automatic send_chunk();
    int i;
    for (i = 0; i < chunk_bytes.size(); i++) begin
      send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    end
  endtask

  task automatic push_delta();
    int n;
    int pick;
    pick = $urandom_range(0, 19);
    n = (pick < 12) ? 1 : (pick < 16) ? 2 : (pick < 18) ? 3 : (pick < 19) ? 4 : 5;
    repeat (n - 1) append_byte(8'($urandom_range(0, 127)) | mtep_pkg::DATA_MASK_BIT);
    append_byte(8'($urandom_range(0, 127)));
  endtask

  task automatic push_length(input int len);
    if ($urandom_range(0, 7) == 0) append_byte(mtep_pkg::DATA_MASK_BIT);
    if (len > 127) append_byte(8'((len >> 7) & 8'h7F) | mtep_pkg::DATA_MASK_BIT);
    append_byte(8'(len & 8'h7F));
  endtask

  task automatic push_body();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
    push_length(len);
    repeat (len) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic build_track();
    int         count;
    int         pick;
    int         cut;
    logic [7:0] status;
    logic [7:0] channel_status;
    logic [7:0] meta_type;
    bit         have_channel;
    chunk_bytes.delete();
    have_channel = 1'b0;
    channel_status = 8'h00;
    count = $urandom_range(1, 8);
    repeat (count) begin
      push_delta();
      pick = $urandom_range(0, 15);
      if (pick < 9) begin
        if (have_channel && $urandom_range(0, 2) == 0) begin
          status = channel_status;
        end else begin
          status = 8'($urandom_range(8'h80, 8'hEF));
          append_byte(status);
          channel_status = status;
          have_channel = 1'b1;
        end
        append_byte(8'($urandom_range(0, 127)));
        if (status[7:4] != mtep_pkg::HI_PROGRAM && status[7:4] != mtep_pkg::HI_PRESSURE)
          append_byte(8'($urandom_range(0, 127)));
      end else if (pick < 11) begin
        append_byte($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
        push_body();
        have_channel = 1'b0;
      end else if (pick < 14) begin
        meta_type = 8'($urandom_range(0, 255));
        if (meta_type == mtep_pkg::META_END_TYPE) meta_type = 8'h01;
        append_byte(8'hFF);
        append_byte(meta_type);
        push_body();
        have_channel = 1'b0;
      end else begin
        status = 8'($urandom_range(8'hF1, 8'hFE));
        if (status == 8'hF7) status = 8'hF8;
        append_byte(status);
        have_channel = 1'b0;
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      push_delta();
      append_byte(8'hFF);
      append_byte(mtep_pkg::META_END_TYPE);
      if (pick < 5) begin
        append_byte(8'h00);
      end else begin
        append_byte(8'($urandom_range(1, 3)));
        if (pick == 6) repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick == 7) begin
      repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, chunk_bytes.size());
      while (chunk_bytes.size() > cut) void'(chunk_bytes.pop_back());
    end
  endtask

  task automatic build_noise();
    chunk_bytes.delete();
    repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int sent;
    bit hold_done;
    sent = 0;
    hold_done = 1'b0;
    rst                <= 1'b1;
    track_if.valid     <= 1'b0;
    track_if.byte_in   <= 8'h00;
    track_if.chunk_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    chunk_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h45, 8'h00};
    send_chunk();
    chunk_bytes = '{8'h00, 8'h40, 8'h7F};
    send_chunk();
    chunk_bytes = '{8'h00, 8'hFF, 8'h2F, 8'h01, 8'h00};
    send_chunk();
    chunk_bytes = '{8'h00, 8'hF6, 8'h05, 8'hC3};
    send_chunk();
    chunk_bytes = '{8'h00, 8'hF0, 8'h81};
    send_chunk();

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) build_track();
      else build_noise();
      fast_in = ($urandom_range(0, 3) == 0);
      if (!hold_done && sent > RANDOM_ITEMS / 3) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      send_chunk();
      sent += chunk_bytes.size();
    end
    track_if.valid <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("** midi_track_event_parser_unit: PASSED **");
    end else begin
      $display("** midi_track_event_parser_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    mtep_pkg::result_t got;
    int                gap;
    int                served;
    served = 0;
    events_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = fast_out ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        events_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      events_if.ready <= 1'b1;
      @(posedge clk);
      while (!events_if.valid) @(posedge clk);
      got.kind          = mtep_pkg::kind_t'(events_if.kind);
      got.status_byte   = events_if.status_byte;
      got.first_data    = events_if.first_data;
      got.second_data   = events_if.second_data;
      got.bytes_present = events_if.bytes_present;
      got.delta_ticks   = events_if.delta_ticks;
      got.tick_total    = events_if.tick_total;
      got.last_of_run   = events_if.last_of_run;
      board.check_result(got);
      served++;
      if (served % 64 == 0) fast_out = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
`default_nettype wire
